// ----- hw/rtl/complex_arithmetic_unit_assert.svh -----
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared property forms for the complex arithmetic unit checks
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("complex arithmetic unit check failed");

// implication after a fixed delay
`define CAU_ASSERT_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##(dly) (cons)) \
        else $error("complex arithmetic unit check failed");

`endif

// ----- hw/rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// widths, command and status codes for the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DW  = 32;
    localparam int FB  = 16;
    localparam int CW  = 3;
    localparam int STW = 2;
    localparam int PW  = 2 * DW;
    localparam int MW  = PW;
    localparam int QW  = DW + 2;
    localparam int LAT = QW + 1;
    localparam int OUT_LAT = LAT + 4;

    localparam logic [CW-1:0] CMD_ADD = 3'd0;
    localparam logic [CW-1:0] CMD_SUB = 3'd1;
    localparam logic [CW-1:0] CMD_MUL = 3'd2;
    localparam logic [CW-1:0] CMD_DIV = 3'd3;
    localparam logic [CW-1:0] CMD_MOD = 3'd4;

    localparam logic [STW-1:0] ST_OK  = 2'd0;
    localparam logic [STW-1:0] ST_DZ  = 2'd1;
    localparam logic [STW-1:0] ST_SAT = 2'd2;

    localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MAX_NEG = {1'b1, {(DW-1){1'b0}}};

endpackage

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// complex arithmetic unit
// add, subtract, multiply, divide and modulus on signed Q16.16 complex values
// ----------------------------------------------------------------------------
// One request is taken per clock whenever start is high; busy stays low, so
// requests may follow each other every cycle. Every result appears exactly
// 39 cycles after its request, with o_strobe high for one cycle, in request
// order, and must be taken then. The latency is set by the 34-stage restoring
// dividers (one quotient bit per stage, one per result part) plus the
// multiply, sum and sign stages ahead of them and the output register; the
// square root for the modulus runs in a matching 34-stage pipeline.
module complex_arithmetic_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cau_pkg::CW-1:0]        i_cmd,
    input  logic signed [cau_pkg::DW-1:0] i_a_re,
    input  logic signed [cau_pkg::DW-1:0] i_a_im,
    input  logic signed [cau_pkg::DW-1:0] i_b_re,
    input  logic signed [cau_pkg::DW-1:0] i_b_im,
    output logic                          o_strobe,
    output logic signed [cau_pkg::DW-1:0] o_res_re,
    output logic signed [cau_pkg::DW-1:0] o_res_im,
    output logic [cau_pkg::STW-1:0]       o_status
);
    import cau_pkg::*;

    `include "complex_arithmetic_unit_assert.svh"

    typedef struct packed {
        logic [CW-1:0]  cmd;
        logic [DW-1:0]  e_re;
        logic [DW-1:0]  e_im;
        logic [STW-1:0] e_sts;
        logic           neg_re;
        logic           neg_im;
        logic           dz;
    } t_side;

    function automatic logic [DW:0] sat_as(input logic [DW:0] v);
        logic sat;
        sat = v[DW] != v[DW-1];
        return {sat, sat ? (v[DW] ? MAX_NEG : MAX_POS) : v[DW-1:0]};
    endfunction

    function automatic logic [DW:0] sat_ml(input logic [PW:0] v);
        logic [PW-FB-DW+1:0] hi;
        logic                sat;
        hi  = v[PW:FB+DW-1];
        sat = !((&hi) || (~|hi));
        return {sat, sat ? (v[PW] ? MAX_NEG : MAX_POS) : v[FB+DW-1:FB]};
    endfunction

    function automatic logic [DW:0] sat_q(input logic [QW-1:0] q, input logic ovf,
                                          input logic neg);
        logic big;
        logic sat;
        big = ovf || (q[QW-1:DW] != '0);
        if (!neg) begin
            sat = big || q[DW-1];
            return {sat, sat ? MAX_POS : q[DW-1:0]};
        end
        sat = big || (q[DW-1] && (q[DW-2:0] != '0));
        return {sat, sat ? MAX_NEG : (~q[DW-1:0] + 1'b1)};
    endfunction

    assign busy = 1'b0;

    // stage 1: products and add / subtract sums
    logic                 r_v1;
    logic [CW-1:0]        r_cmd1;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic [DW:0]          r_as_re1, r_as_im1;
    logic signed [DW-1:0] n_x, n_y;
    logic [DW:0]          n_as_re, n_as_im;

    always_comb begin
        n_x = (i_cmd == CMD_MOD) ? i_a_re : i_b_re;
        n_y = (i_cmd == CMD_MOD) ? i_a_im : i_b_im;
        if (i_cmd == CMD_SUB) begin
            n_as_re = {i_a_re[DW-1], i_a_re} - {i_b_re[DW-1], i_b_re};
            n_as_im = {i_a_im[DW-1], i_a_im} - {i_b_im[DW-1], i_b_im};
        end else begin
            n_as_re = {i_a_re[DW-1], i_a_re} + {i_b_re[DW-1], i_b_re};
            n_as_im = {i_a_im[DW-1], i_a_im} + {i_b_im[DW-1], i_b_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd1   <= i_cmd;
        r_p0     <= i_a_re * i_b_re;
        r_p1     <= i_a_im * i_b_im;
        r_p2     <= i_a_re * i_b_im;
        r_p3     <= i_a_im * i_b_re;
        r_p4     <= n_x * n_x;
        r_p5     <= n_y * n_y;
        r_as_re1 <= n_as_re;
        r_as_im1 <= n_as_im;
    end

    // stage 2: sums of products
    logic          r_v2;
    logic [CW-1:0] r_cmd2;
    logic [PW:0]   r_sum_re, r_sum_im;
    logic [MW-1:0] r_sq2;
    logic [DW:0]   r_as_re2, r_as_im2;
    logic [PW:0]   n_sum_re, n_sum_im;

    always_comb begin
        if (r_cmd1 == CMD_MUL) begin
            n_sum_re = {r_p0[PW-1], r_p0} - {r_p1[PW-1], r_p1};
            n_sum_im = {r_p2[PW-1], r_p2} + {r_p3[PW-1], r_p3};
        end else begin
            n_sum_re = {r_p0[PW-1], r_p0} + {r_p1[PW-1], r_p1};
            n_sum_im = {r_p3[PW-1], r_p3} - {r_p2[PW-1], r_p2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd2   <= r_cmd1;
        r_sum_re <= n_sum_re;
        r_sum_im <= n_sum_im;
        r_sq2    <= r_p4 + r_p5;
        r_as_re2 <= r_as_re1;
        r_as_im2 <= r_as_im1;
    end

    // stage 3: early results, dividend magnitudes and signs
    logic          r_v3;
    t_side         r_sb3;
    logic [MW-1:0] r_nre3, r_nim3, r_sq3;
    t_side         n_sb3;
    logic [PW:0]   n_abs_re, n_abs_im;
    logic [DW:0]   n_fre, n_fim;

    always_comb begin
        n_abs_re = r_sum_re[PW] ? (~r_sum_re + 1'b1) : r_sum_re;
        n_abs_im = r_sum_im[PW] ? (~r_sum_im + 1'b1) : r_sum_im;
        case (r_cmd2)
            CMD_ADD, CMD_SUB: begin
                n_fre = sat_as(r_as_re2);
                n_fim = sat_as(r_as_im2);
            end
            CMD_MUL: begin
                n_fre = sat_ml(r_sum_re);
                n_fim = sat_ml(r_sum_im);
            end
            default: begin
                n_fre = '0;
                n_fim = '0;
            end
        endcase
        n_sb3.cmd    = r_cmd2;
        n_sb3.e_re   = n_fre[DW-1:0];
        n_sb3.e_im   = n_fim[DW-1:0];
        n_sb3.e_sts  = (n_fre[DW] || n_fim[DW]) ? ST_SAT : ST_OK;
        n_sb3.neg_re = r_sum_re[PW];
        n_sb3.neg_im = r_sum_im[PW];
        n_sb3.dz     = r_sq2 == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb3  <= n_sb3;
        r_nre3 <= n_abs_re[MW-1:0];
        r_nim3 <= n_abs_im[MW-1:0];
        r_sq3  <= r_sq2;
    end

    // divide and square root pipelines
    logic [QW-1:0] w_q_re, w_q_im, w_root;
    logic          w_ovf_re, w_ovf_im;

    cau_div u_div_re (
        .i_clk  (i_clk),
        .i_num  (r_nre3),
        .i_den  (r_sq3),
        .o_quot (w_q_re),
        .o_ovf  (w_ovf_re)
    );

    cau_div u_div_im (
        .i_clk  (i_clk),
        .i_num  (r_nim3),
        .i_den  (r_sq3),
        .o_quot (w_q_im),
        .o_ovf  (w_ovf_im)
    );

    cau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_sq3),
        .o_root (w_root)
    );

    // side data delay matching the divider
    logic [LAT-1:0] r_vd;
    t_side          r_sb [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else begin
            r_vd <= {r_vd[LAT-2:0], r_v3};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= r_sb3;
        for (int i = 1; i < LAT; i++) begin
            r_sb[i] <= r_sb[i-1];
        end
    end

    // output stage
    t_side          w_sb;
    logic [DW:0]    n_qre, n_qim;
    logic [DW-1:0]  n_o_re, n_o_im;
    logic [STW-1:0] n_o_sts;
    logic           n_rsat;

    always_comb begin
        w_sb   = r_sb[LAT-1];
        n_qre  = sat_q(w_q_re, w_ovf_re, w_sb.neg_re);
        n_qim  = sat_q(w_q_im, w_ovf_im, w_sb.neg_im);
        n_rsat = w_root[QW-1:DW-1] != '0;
        case (w_sb.cmd)
            CMD_DIV: begin
                if (w_sb.dz) begin
                    n_o_re  = '0;
                    n_o_im  = '0;
                    n_o_sts = ST_DZ;
                end else begin
                    n_o_re  = n_qre[DW-1:0];
                    n_o_im  = n_qim[DW-1:0];
                    n_o_sts = (n_qre[DW] || n_qim[DW]) ? ST_SAT : ST_OK;
                end
            end
            CMD_MOD: begin
                n_o_re  = n_rsat ? MAX_POS : w_root[DW-1:0];
                n_o_im  = '0;
                n_o_sts = n_rsat ? ST_SAT : ST_OK;
            end
            default: begin
                n_o_re  = w_sb.e_re;
                n_o_im  = w_sb.e_im;
                n_o_sts = w_sb.e_sts;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_vd[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res_re <= n_o_re;
        o_res_im <= n_o_im;
        o_status <= n_o_sts;
    end

    // checks
    `CAU_ASSERT_DLY(a_latency, start && !busy, OUT_LAT, o_strobe)
    `CAU_ASSERT_IMP(a_no_spurious, o_strobe, $past(start, OUT_LAT))
    `CAU_ASSERT_IMP(a_dz_zero, o_strobe && (o_status == ST_DZ),
        (o_res_re == '0) && (o_res_im == '0))

endmodule

// ----- hw/rtl/cau_div.sv -----
// ----------------------------------------------------------------------------
// cau_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module cau_div (
    input  logic                  i_clk,
    input  logic [cau_pkg::MW-1:0] i_num,
    input  logic [cau_pkg::MW-1:0] i_den,
    output logic [cau_pkg::QW-1:0] o_quot,
    output logic                  o_ovf
);
    import cau_pkg::*;

    logic [MW-1:0] r_rem [QW+1];
    logic [MW-1:0] r_den [QW+1];
    logic [QW-1:0] r_dq  [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_ovf [QW+1];

    // quotient fits QW bits only when num / 2^(QW-FB) is below den
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num >> (QW - FB);
        r_dq[0]  <= {i_num[QW-FB-1:0], {FB{1'b0}}};
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_ovf[0] <= (i_num >> (QW - FB)) >= i_den;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [MW:0] n_t;
        logic [MW:0] n_d;
        logic        n_ge;

        always_comb begin
            n_t  = {r_rem[k], r_dq[k][QW-1]};
            n_ge = n_t >= {1'b0, r_den[k]};
            n_d  = n_ge ? (n_t - {1'b0, r_den[k]}) : n_t;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_d[MW-1:0];
            r_dq[k+1]  <= r_dq[k] << 1;
            r_q[k+1]   <= {r_q[k][QW-2:0], n_ge};
            r_den[k+1] <= r_den[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    assign o_quot = r_q[QW];
    assign o_ovf  = r_ovf[QW];

endmodule

// ----- hw/rtl/cau_sqrt.sv -----
// ----------------------------------------------------------------------------
// cau_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module cau_sqrt (
    input  logic                  i_clk,
    input  logic [cau_pkg::MW-1:0] i_rad,
    output logic [cau_pkg::QW-1:0] o_root
);
    import cau_pkg::*;

    localparam int RW  = 2 * QW;
    localparam int REW = QW + 2;

    logic [RW-1:0]  r_s    [QW+1];
    logic [REW-1:0] r_rem  [QW+1];
    logic [QW-1:0]  r_root [QW+1];

    always_ff @(posedge i_clk) begin
        r_s[0]    <= {{(RW-MW){1'b0}}, i_rad};
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [REW+1:0] n_t;
        logic [REW+1:0] n_tr;
        logic [REW+1:0] n_d;
        logic           n_ge;

        always_comb begin
            n_t  = {r_rem[k], r_s[k][RW-1:RW-2]};
            n_tr = {2'b00, r_root[k], 2'b01};
            n_ge = n_t >= n_tr;
            n_d  = n_ge ? (n_t - n_tr) : n_t;
        end

        always_ff @(posedge i_clk) begin
            r_s[k+1]    <= r_s[k] << 2;
            r_rem[k+1]  <= n_d[REW-1:0];
            r_root[k+1] <= {r_root[k][QW-2:0], n_ge};
        end
    end

    assign o_root = r_root[QW];

endmodule

// ----- test/complex_arithmetic_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex arithmetic unit testbench
// drives add, subtract, multiply, divide, modulus and unused command codes
// with directed corner operands and random operands, predicts each result
// with exact wide arithmetic and checks results in request order
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic [STW-1:0]       st;
    } cplx_result_t;

    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [CW-1:0]        i_cmd;
    logic signed [DW-1:0] i_a_re, i_a_im, i_b_re, i_b_im;
    logic                 o_strobe;
    logic signed [DW-1:0] o_res_re, o_res_im;
    logic [STW-1:0]       o_status;

    cplx_result_t pending_results[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           sender_idle_pct = 0;

    complex_arithmetic_unit dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [127:0] isqrt(logic [127:0] s);
        logic [127:0] res;
        logic [127:0] bt;
        res = 0;
        bt  = 128'd1 << 62;
        while (bt > s) bt = bt >> 2;
        while (bt != 0) begin
            if (s >= res + bt) begin
                s   = s - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [127:0] div_trunc(logic signed [127:0] num,
                                                      logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? $unsigned(-num) : $unsigned(num);
        q   = (mag << FB) / den;
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [DW-1:0] clamp(logic signed [127:0] v, inout logic sat);
        if (v > SAT_HI) begin
            sat = 1'b1;
            return MAX_POS;
        end
        if (v < SAT_LO) begin
            sat = 1'b1;
            return MAX_NEG;
        end
        return v[DW-1:0];
    endfunction

    function automatic cplx_result_t compute_result(logic [CW-1:0] cmd,
                                                    logic signed [DW-1:0] xr,
                                                    logic signed [DW-1:0] xi,
                                                    logic signed [DW-1:0] yr,
                                                    logic signed [DW-1:0] yi);
        logic signed [127:0] ar, ai, br, bi, re, im;
        logic [127:0]        den;
        logic                sat;
        cplx_result_t        r;
        ar  = xr;
        ai  = xi;
        br  = yr;
        bi  = yi;
        re  = 0;
        im  = 0;
        sat = 1'b0;
        case (cmd)
            CMD_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            CMD_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            CMD_MUL: begin
                re = (ar * br - ai * bi) >>> FB;
                im = (ar * bi + ai * br) >>> FB;
            end
            CMD_DIV: begin
                den = $unsigned(br * br + bi * bi);
                if (den == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.st = ST_DZ;
                    return r;
                end
                re = div_trunc(ar * br + ai * bi, den);
                im = div_trunc(ai * br - ar * bi, den);
            end
            CMD_MOD: begin
                re = $signed(isqrt($unsigned(ar * ar + ai * ai)));
            end
            default: begin
            end
        endcase
        r.re = clamp(re, sat);
        r.im = clamp(im, sat);
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // request capture, result checking and watchdog
    always @(posedge i_clk) begin
        cplx_result_t exp_r;
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (start && !busy) begin
                pending_results.push_back(compute_result(i_cmd, i_a_re, i_a_im,
                                                         i_b_re, i_b_im));
            end
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_res_re !== exp_r.re)
                        report_mismatch($sformatf("res_re %h, expected %h",
                                                  o_res_re, exp_r.re));
                    if (o_res_im !== exp_r.im)
                        report_mismatch($sformatf("res_im %h, expected %h",
                                                  o_res_im, exp_r.im));
                    if (o_status !== exp_r.st)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, exp_r.st));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("complex_arithmetic_unit test failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [CW-1:0] cmd,
                                input logic [DW-1:0] ar, input logic [DW-1:0] ai,
                                input logic [DW-1:0] br, input logic [DW-1:0] bi);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_cmd  <= cmd;
        i_a_re <= ar;
        i_a_im <= ai;
        i_b_re <= br;
        i_b_im <= bi;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            3:    return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
            4: begin
                case ($urandom_range(3))
                    0: return MAX_POS;
                    1: return MAX_NEG;
                    2: return '0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    task automatic test_directed();
        logic [CW-1:0] c;
        for (int k = 0; k < 5; k++) begin
            c = CW'(k);
            send_request(c, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG);
            send_request(c, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
            send_request(c, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000);
        end
        send_request(CMD_DIV, 32'h0001_0000, 32'h0001_0000, '0, '0);
        send_request(CMD_DIV, MAX_POS, MAX_POS, 32'h0000_0001, '0);
        send_request(CMD_DIV, 32'hFFFF_FFFF, '0, MAX_NEG, '0);
        send_request(CMD_MOD, '0, '0, '0, '0);
        send_request(CMD_MUL, MAX_POS, MAX_POS, MAX_POS, MAX_NEG);
        for (int k = 5; k < 8; k++) begin
            c = CW'(k);
            send_request(c, MAX_POS, MAX_NEG, 32'h1234_5678, 32'h8765_4321);
        end
        wait_for_results();
    endtask

    task automatic test_random(input int count, input int idle_pct);
        logic [CW-1:0] c;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            c = ($urandom_range(19) == 0) ? CW'($urandom_range(5, 7))
                                          : CW'($urandom_range(0, 4));
            if (c == CMD_DIV && $urandom_range(15) == 0)
                send_request(c, pick_operand(), pick_operand(), '0, '0);
            else
                send_request(c, pick_operand(), pick_operand(), pick_operand(),
                             pick_operand());
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        i_a_re  = '0;
        i_a_im  = '0;
        i_b_re  = '0;
        i_b_im  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(600, 35);
        test_random(600, 46);
        test_random(630, 0);
        repeat (OUT_LAT + 10) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("complex_arithmetic_unit test passed");
        end else begin
            $display("complex_arithmetic_unit test failed");
        end
        $finish;
    end
endmodule
